// ===== hw/rtl/sch_pkg.sv =====
package sch_pkg;

  localparam logic [31:0] POLY_HIGH    = 32'h0060_0340;
  localparam logic [31:0] POLY_LOW_NEW = 32'h00F0_D50B;
  localparam logic [31:0] POLY_LOW_OLD = 32'h00F0_D50A;
  localparam logic [63:0] SEED_CRC     = 64'hFAC4_32B1_0CD5_E44A;
  localparam logic [22:0] MOD_ONE      = 23'd7834891;
  localparam logic [22:0] MOD_TWO      = 23'd6017489;
  localparam logic [22:0] SEED_RES_ONE = 23'h34_629D;
  localparam logic [22:0] SEED_RES_TWO = 23'h73_95DD;
  localparam logic [31:0] SEED_MIX     = 32'h1A3F_5C4F;
  localparam logic [31:0] LOW31        = 32'h7FFF_FFFF;
  localparam logic [31:0] TOP_BIT      = 32'h8000_0000;

  // floor(2^31 / m); quotient estimate from it is low by at most one
  localparam logic [8:0] RECIP_ONE = 9'((64'd1 << 31) / {41'd0, MOD_ONE});
  localparam logic [8:0] RECIP_TWO = 9'((64'd1 << 31) / {41'd0, MOD_TWO});

  // hash_method codes; the unused code hashes like the prime method
  localparam logic [1:0] METHOD_CRC     = 2'd0;
  localparam logic [1:0] METHOD_OLD_CRC = 2'd1;
  localparam logic [1:0] METHOD_PRIME   = 2'd2;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       has_byte;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [31:0] hash_first;
    logic [31:0] hash_second;
  } out_word_t;

  // CRC table entry built from the polynomial, returned as {hi, lo}
  function automatic logic [63:0] crc_entry(input logic [7:0] idx, input logic old_poly);
    logic [63:0] v;
    v = '0;
    for (int j = 7; j >= 0; j--) begin
      if (idx[j]) begin
        v = v ^ {(old_poly ? POLY_LOW_OLD : POLY_LOW_NEW), POLY_HIGH};
      end
      v = {v[62:0], 1'b0};
    end
    return {v[31:0], v[63:32]};
  endfunction

  // (r * b) mod m: full product, quotient estimate by reciprocal, one fixup.
  // Any 23-bit r works, the product stays below 2^31.
  function automatic logic [22:0] mul_mod(input logic [22:0] r, input logic [7:0] b,
                                          input logic [22:0] m, input logic [8:0] recip);
    logic [30:0] prod;
    logic [39:0] scaled;
    logic [8:0]  quot;
    logic [31:0] rem;
    prod   = {8'd0, r} * {23'd0, b};
    scaled = {9'd0, prod} * {31'd0, recip};
    quot   = scaled[39:31];
    rem    = {1'b0, prod} - ({23'd0, quot} * {9'd0, m});
    if (rem >= {9'd0, m}) begin
      rem = rem - {9'd0, m};
    end
    return rem[22:0];
  endfunction

  function automatic logic [31:0] crc_fold(input logic [31:0] w);
    return w[31] ? ((w & LOW31) | 32'd1) : w;
  endfunction

endpackage

// ===== hw/rtl/sch_core.sv =====
module sch_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  sch_pkg::in_word_t in_word,
  input  logic [1:0]        hash_method,
  output logic              emit,
  output sch_pkg::out_word_t result
);

  logic [63:0] crc_r, crc_nxt;
  logic [22:0] res_one_r, res_one_nxt;
  logic [22:0] res_two_r, res_two_nxt;
  logic [31:0] mix_r, mix_nxt;

  logic [63:0] entry;
  logic [31:0] hi_new, lo_new, sra23;
  logic [63:0] crc_abs;
  logic [22:0] res_one_abs, res_two_abs;
  logic [31:0] mix_abs;

  // absorb one byte
  always_comb begin
    entry  = sch_pkg::crc_entry(crc_r[63:56], hash_method == sch_pkg::METHOD_OLD_CRC);
    hi_new = {crc_r[55:32], 8'h00} ^ {24'h0, crc_r[31:24]} ^ entry[63:32];
    lo_new = {crc_r[23:0], 8'h00} ^ {24'h0, in_word.byte_value} ^ entry[31:0];
    sra23  = 32'($signed(mix_r) >>> 23);
    if (in_word.has_byte) begin
      crc_abs     = {hi_new, lo_new};
      res_one_abs = sch_pkg::mul_mod(res_one_r, in_word.byte_value, sch_pkg::MOD_ONE,
                                     sch_pkg::RECIP_ONE);
      res_two_abs = sch_pkg::mul_mod(res_two_r, in_word.byte_value, sch_pkg::MOD_TWO,
                                     sch_pkg::RECIP_TWO);
      mix_abs     = {mix_r[26:0], 5'b0} ^ {24'h0, in_word.byte_value} ^ sra23;
    end else begin
      crc_abs     = crc_r;
      res_one_abs = res_one_r;
      res_two_abs = res_two_r;
      mix_abs     = mix_r;
    end
  end

  // finish from the post-absorb state
  always_comb begin
    case (hash_method) inside
      sch_pkg::METHOD_CRC, sch_pkg::METHOD_OLD_CRC: begin
        result.hash_first  = sch_pkg::crc_fold(crc_abs[63:32]) | sch_pkg::TOP_BIT;
        result.hash_second = sch_pkg::crc_fold(crc_abs[31:0]);
      end
      default: begin
        result.hash_first  = ({9'h0, res_one_abs} ^ {mix_abs[17:0], 14'h0}) & sch_pkg::LOW31;
        result.hash_second = ({9'h0, res_two_abs} ^ {mix_abs[11:0], 20'h0}) & sch_pkg::LOW31;
      end
    endcase
  end

  assign emit = fire && in_word.last;

  always_comb begin
    crc_nxt     = crc_r;
    res_one_nxt = res_one_r;
    res_two_nxt = res_two_r;
    mix_nxt     = mix_r;
    if (emit) begin
      crc_nxt     = sch_pkg::SEED_CRC;
      res_one_nxt = sch_pkg::SEED_RES_ONE;
      res_two_nxt = sch_pkg::SEED_RES_TWO;
      mix_nxt     = sch_pkg::SEED_MIX;
    end else if (fire) begin
      crc_nxt     = crc_abs;
      res_one_nxt = res_one_abs;
      res_two_nxt = res_two_abs;
      mix_nxt     = mix_abs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r     <= sch_pkg::SEED_CRC;
      res_one_r <= sch_pkg::SEED_RES_ONE;
      res_two_r <= sch_pkg::SEED_RES_TWO;
      mix_r     <= sch_pkg::SEED_MIX;
    end else begin
      crc_r     <= crc_nxt;
      res_one_r <= res_one_nxt;
      res_two_r <= res_two_nxt;
      mix_r     <= mix_nxt;
    end
  end

  // residues are reduced once a byte is in; the second seed sits above its prime
  a_res_one_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    res_one_r < sch_pkg::MOD_ONE) else $error("residue_one not reduced");
  a_res_two_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (res_two_r < sch_pkg::MOD_TWO) || (res_two_r == sch_pkg::SEED_RES_TWO))
    else $error("residue_two not reduced");
  a_crc_top_set: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && (hash_method == sch_pkg::METHOD_CRC || hash_method == sch_pkg::METHOD_OLD_CRC))
      |-> result.hash_first[31]) else $error("CRC first word lacks top bit");
  a_second_top_clear: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !result.hash_second[31]) else $error("second word top bit set");
  a_reseed: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (crc_r == sch_pkg::SEED_CRC && mix_r == sch_pkg::SEED_MIX))
    else $error("state not reseeded after a result");

endmodule

// ===== hw/rtl/sch_out_stage.sv =====
module sch_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  sch_pkg::out_word_t load_word,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_ready,
  output sch_pkg::out_word_t out_data
);

  logic               valid_r, valid_nxt;
  sch_pkg::out_word_t data_r;

  // free when empty or being drained this cycle
  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_word;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== hw/rtl/string_crc64_prime_hasher.sv =====
// String hasher: two 32-bit hash words per string.
// in_*  : one word per string byte (byte_value, has_byte, last), valid/ready.
//         has_byte = 0 absorbs nothing; last = 1 closes the string.
// out_* : one word {hash_first, hash_second} per closed string, valid/ready.
// cfg_* : writes hash_method (0 CRC64, 1 old CRC64, 2 prime hash; 3 acts as 2).
//         Always ready; write only while no string result is pending.
// Throughput: one input word per cycle while in_ready is high. The byte
// absorb (CRC step, two modular products reduced by a reciprocal quotient
// estimate, mixer) is one registered update per word.
// Latency: the result is registered and shows on out_valid the cycle after
// the closing word is accepted.
// Stall: the result register holds while out_ready is low; in_ready drops
// only if a result is held and not being taken, so input keeps flowing
// through non-closing words only when the result register is free.
// Reset (rst_n low, synchronous): method = CRC64, hash state at its seeds,
// no result pending. After every result the hash state reseeds.
module string_crc64_prime_hasher (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sch_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sch_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_data
);

  logic [1:0]         method_r;
  logic               fire;
  logic               emit;
  logic               can_load;
  sch_pkg::out_word_t result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r <= sch_pkg::METHOD_CRC;
    end else if (cfg_valid) begin
      method_r <= cfg_data;
    end
  end

  // a word is taken whenever the result register can absorb a new result
  assign in_ready = can_load;
  assign fire     = in_valid && in_ready;

  sch_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .in_word     (in_data),
    .hash_method (method_r),
    .emit        (emit),
    .result      (result)
  );

  sch_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (emit),
    .load_word (result),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_data.last) |=> out_valid) else $error("closing word gave no result");
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready) else $error("input taken over held result");
  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid && !(fire && in_data.last)) |=> !out_valid)
    else $error("result without closing word");

endmodule

// ===== test/tb_string_crc64_prime_hasher.sv =====
module tb_string_crc64_prime_hasher;
  timeunit 1ns;
  timeprecision 1ps;

  // spare method code; the block hashes it like the prime method
  localparam logic [1:0] METHOD_SPARE = 2'd3;
  // cycles with no handshake on any port before the run is declared hung
  localparam int STALL_LIMIT = 1000;
  localparam int PHASES      = 12;
  localparam int PHASE_WORDS = 120;

  // Running model of the hasher: CRC64 and prime-product state, the current
  // method, and the hash words owed by the block, oldest first.
  class hash_board;
    logic [1:0]         method;
    logic [63:0]        crc_state;
    logic [22:0]        prod_one;
    logic [22:0]        prod_two;
    logic [31:0]        mix_state;
    sch_pkg::out_word_t pending_hashes[$];
    int                 errors;

    function new();
      method = sch_pkg::METHOD_CRC;
      errors = 0;
      reseed();
    endfunction

    function void reseed();
      crc_state = sch_pkg::SEED_CRC;
      prod_one  = sch_pkg::SEED_RES_ONE;
      prod_two  = sch_pkg::SEED_RES_TWO;
      mix_state = sch_pkg::SEED_MIX;
    endfunction

    // CRC row for one index byte, {hi, lo}; lo shifts in the top bit of hi
    function logic [63:0] poly_row(logic [7:0] idx, logic old_poly);
      logic [31:0] a;
      logic [31:0] b;
      logic [7:0]  v;
      a = '0;
      b = '0;
      v = idx;
      for (int j = 0; j < 8; j++) begin
        if (v[7]) begin
          a = a ^ sch_pkg::POLY_HIGH;
          b = b ^ (old_poly ? sch_pkg::POLY_LOW_OLD : sch_pkg::POLY_LOW_NEW);
        end
        b = {b[30:0], a[31]};
        a = a << 1;
        v = v << 1;
      end
      return {a, b};
    endfunction

    // top bit set: clear it and force bit 0 (flawed fold, kept on purpose)
    function logic [31:0] fold_word(logic [31:0] w);
      return w[31] ? {1'b0, w[30:1], 1'b1} : w;
    endfunction

    function void absorb_word(sch_pkg::in_word_t w);
      logic [63:0]        row;
      logic [31:0]        hi;
      logic [31:0]        lo;
      logic [31:0]        p1;
      logic [31:0]        p2;
      logic [31:0]        b32;
      sch_pkg::out_word_t h;
      b32 = {24'd0, w.byte_value};
      if (w.has_byte) begin
        hi  = crc_state[63:32];
        lo  = crc_state[31:0];
        row = poly_row(hi[31:24], method == sch_pkg::METHOD_OLD_CRC);
        crc_state = {(hi << 8) ^ (lo >> 24) ^ row[63:32], (lo << 8) ^ b32 ^ row[31:0]};
        p1 = {9'd0, prod_one} * b32;
        p2 = {9'd0, prod_two} * b32;
        prod_one = 23'(p1 % {9'd0, sch_pkg::MOD_ONE});
        prod_two = 23'(p2 % {9'd0, sch_pkg::MOD_TWO});
        mix_state = (mix_state << 5) ^ b32 ^ 32'($signed(mix_state) >>> 23);
      end
      if (w.last) begin
        if (method == sch_pkg::METHOD_CRC || method == sch_pkg::METHOD_OLD_CRC) begin
          h.hash_first  = fold_word(crc_state[63:32]) | sch_pkg::TOP_BIT;
          h.hash_second = fold_word(crc_state[31:0]);
        end else begin
          h.hash_first  = ({9'd0, prod_one} ^ (mix_state << 14)) & sch_pkg::LOW31;
          h.hash_second = ({9'd0, prod_two} ^ (mix_state << 20)) & sch_pkg::LOW31;
        end
        pending_hashes.push_back(h);
        reseed();
      end
    endfunction

    function void check_hash(sch_pkg::out_word_t got);
      sch_pkg::out_word_t want;
      if (pending_hashes.size() == 0) begin
        $error("hash word with nothing pending: hash_first %h hash_second %h",
               got.hash_first, got.hash_second);
        errors++;
        return;
      end
      want = pending_hashes.pop_front();
      if (got.hash_first !== want.hash_first) begin
        $error("hash_first: expected %h, got %h", want.hash_first, got.hash_first);
        errors++;
      end
      if (got.hash_second !== want.hash_second) begin
        $error("hash_second: expected %h, got %h", want.hash_second, got.hash_second);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  sch_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  sch_pkg::out_word_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_data = sch_pkg::METHOD_CRC;

  hash_board board;
  bit        calm = 1'b0;   // no idling on either side in the closing phases
  int        stall_count = 0;
  int        words_sent = 0;

  logic [1:0] dir_methods [4] = '{sch_pkg::METHOD_CRC, sch_pkg::METHOD_OLD_CRC,
                                  sch_pkg::METHOD_PRIME, METHOD_SPARE};

  string_crc64_prime_hasher uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: random bursts of back-pressure between ready stretches.
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Handshake monitor. Everything is sampled at the edge, before the
  // nonblocking updates of that edge land, so the values seen are the
  // ones the block saw. Results are checked before the input word of
  // the same edge is absorbed; a result can only come from an earlier word.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        board.check_hash(out_data);
      end
      if (in_valid && in_ready) begin
        board.absorb_word(in_data);
      end
      if (cfg_valid && cfg_ready) begin
        board.method = cfg_data;
      end
      if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready)) begin
        stall_count = 0;
      end else begin
        stall_count++;
      end
      if (stall_count >= STALL_LIMIT) begin
        $display("tb_string_crc64_prime_hasher: done, errors");
        $finish;
      end
    end
  end

  // Edge-heavy byte mix: zero, all ones, top bit alone, or anything.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: begin
        return 8'h00;
      end
      1: begin
        return 8'hFF;
      end
      2: begin
        return 8'h80;
      end
      default: begin
        return 8'($urandom);
      end
    endcase
  endfunction

  // Present one word and hold it until taken. Valid stays high afterwards
  // unless a gap follows; every caller that stops sending goes through
  // drain, which drops it.
  task automatic send_word(input sch_pkg::in_word_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    if (w.has_byte || w.last) begin
      words_sent++;
    end
  endtask

  task automatic send_idle();
    sch_pkg::in_word_t w;
    w.byte_value = 8'($urandom);
    w.has_byte   = 1'b0;
    w.last       = 1'b0;
    send_word(w);
  endtask

  // Stop sending, let the monitor take in the last accepted word, wait for
  // every owed hash word, then a few more cycles before the config moves.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_hashes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_method(input logic [1:0] m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One string: random bytes, idle words sprinkled in, closed either on
  // the last byte or by a close-only word (always so for an empty string).
  task automatic send_string();
    int                len;
    bit                close_only;
    sch_pkg::in_word_t w;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    close_only = (len == 0) || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        send_idle();
      end
      w.byte_value = pick_byte();
      w.has_byte   = 1'b1;
      w.last       = !close_only && (i == len - 1);
      send_word(w);
    end
    if (close_only) begin
      w.byte_value = 8'($urandom);
      w.has_byte   = 1'b0;
      w.last       = 1'b1;
      send_word(w);
    end
  endtask

  // Per method: empty string, zero byte closing, all-ones byte, idle word
  // that must leave the state alone, top-bit byte, closing byte.
  task automatic directed_words();
    send_word('{byte_value: 8'h00, has_byte: 1'b0, last: 1'b1});
    send_word('{byte_value: 8'h00, has_byte: 1'b1, last: 1'b1});
    send_word('{byte_value: 8'hFF, has_byte: 1'b1, last: 1'b0});
    send_word('{byte_value: 8'hA5, has_byte: 1'b0, last: 1'b0});
    send_word('{byte_value: 8'h80, has_byte: 1'b1, last: 1'b0});
    send_word('{byte_value: 8'h01, has_byte: 1'b1, last: 1'b1});
  endtask

  initial begin
    int                phase_goal;
    int                pick;
    sch_pkg::in_word_t w;
    board = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed pass through all four method codes
    foreach (dir_methods[k]) begin
      drain();
      set_method(dir_methods[k]);
      directed_words();
    end
    // leave a string open so the next method takes over mid-string
    send_word('{byte_value: 8'h7F, has_byte: 1'b1, last: 1'b0});

    for (int p = 0; p < PHASES; p++) begin
      drain();
      calm = (p >= PHASES - 2);
      set_method(p < 4 ? dir_methods[p] : 2'($urandom_range(0, 3)));
      phase_goal = words_sent + PHASE_WORDS;
      while (words_sent < phase_goal) begin
        pick = $urandom_range(0, 39);
        if (pick < 3) begin
          // noise: any field combination, breaks strings at random points
          w = sch_pkg::in_word_t'(10'($urandom));
          send_word(w);
        end else if (pick == 3 && !calm) begin
          // hold off until the block owes nothing
          drain();
        end else begin
          send_string();
        end
      end
      // sometimes carry an unfinished string across the method change
      if ($urandom_range(0, 1) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          w.byte_value = pick_byte();
          w.has_byte   = 1'b1;
          w.last       = 1'b0;
          send_word(w);
        end
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (board.errors == 0 && board.pending_hashes.size() == 0) begin
      $display("tb_string_crc64_prime_hasher: done, clean");
    end else begin
      $display("tb_string_crc64_prime_hasher: done, errors");
    end
    $finish;
  end

endmodule
